### rtl/core/set_assoc_cache_lru_writeback_assert.svh
// Assertion macros for the set-associative LRU write-back cache controller.
// Standalone header; the top level includes it to check its own logic.
`ifndef SET_ASSOC_CACHE_LRU_WRITEBACK_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_WRITEBACK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SALC_ASSERT_IMP(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SALC_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/core/salc_pkg.sv
// Shared types and helpers of the set-associative LRU write-back cache.
// No dependencies; used by the lookup logic and the top level.
`default_nettype none

package salc_pkg;

   // Fixed field widths of the access and result transfers
   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 32;
   localparam int WAY_OUT_W = 2;

   typedef logic [COUNT_W-1:0] salc_count_type;

   // Status of one lookup, handed from the lookup logic to the control
   typedef struct packed {
      logic hit;
      logic writeback;
   } salc_flags_type;

   // Saturating increment of a running counter
   function automatic salc_count_type salc_sat_inc(input salc_count_type v);
      salc_count_type r;
      r = (v == '1) ? v : v + salc_count_type'(1);
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/salc_ram.sv
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// No dependencies; holds the tag rows and the line state rows of the cache.
`default_nettype none

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/salc_lookup.sv
// Way compare, victim choice and LRU / dirty / tag update for one cache set.
// Depends on salc_pkg for the lookup status struct.
`default_nettype none

module salc_lookup import salc_pkg::*; #(
   parameter int WAYS  = 4,
   parameter int TAG_W = 20,
   parameter int WAY_W = 2
) (
   input  wire logic [WAYS*TAG_W-1:0]       tag_row,
   input  wire logic [WAYS*(WAY_W+2)-1:0]   state_row,
   input  wire logic [TAG_W-1:0]            req_tag,
   input  wire logic                        req_write,
   output salc_flags_type                   flags,
   output logic      [WAY_W-1:0]            way,
   output logic      [WAYS*TAG_W-1:0]       new_tag_row,
   output logic      [WAYS*(WAY_W+2)-1:0]   new_state_row
);

   localparam int ENTRY_W = WAY_W + 2;
   localparam logic [WAY_W-1:0] RANK_MAX = WAY_W'(WAYS - 1);

   logic [WAYS-1:0]  valid_w;
   logic [WAYS-1:0]  dirty_w;
   logic [WAYS-1:0]  match_w;
   logic [WAY_W-1:0] rank_w [WAYS];
   logic             hit;
   logic             any_inv;
   logic [WAY_W-1:0] hit_way;
   logic [WAY_W-1:0] inv_way;
   logic [WAY_W-1:0] victim;
   logic [WAY_W-1:0] chosen;
   logic [WAY_W-1:0] old_rank;
   logic             was_valid;

   // Unpack the set rows and compare tags of all ways in parallel
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         valid_w[w] = state_row[w*ENTRY_W + ENTRY_W - 1];
         dirty_w[w] = state_row[w*ENTRY_W + ENTRY_W - 2];
         rank_w[w]  = state_row[w*ENTRY_W +: WAY_W];
         match_w[w] = valid_w[w] && (tag_row[w*TAG_W +: TAG_W] == req_tag);
      end
   end

   // Pick the lowest matching way, the lowest invalid way and the LRU way.
   // Valid ways carry distinct ranks, so a full set has one way at the top rank.
   always_comb begin
      hit     = 1'b0;
      any_inv = 1'b0;
      hit_way = '0;
      inv_way = '0;
      victim  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match_w[w]) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!valid_w[w]) begin
            any_inv = 1'b1;
            inv_way = WAY_W'(w);
         end
         if (rank_w[w] == RANK_MAX) begin
            victim = WAY_W'(w);
         end
      end
   end

   assign chosen    = hit ? hit_way : (any_inv ? inv_way : victim);
   assign old_rank  = rank_w[chosen];
   assign was_valid = hit || !any_inv;

   assign flags.hit       = hit;
   assign flags.writeback = !hit && !any_inv && dirty_w[victim];
   assign way             = chosen;

   // Build the updated rows: touched way goes most recent, ways more recent than it age
   always_comb begin
      for (int k = 0; k < WAYS; k++) begin
         new_tag_row[k*TAG_W +: TAG_W] = tag_row[k*TAG_W +: TAG_W];
         new_state_row[k*ENTRY_W +: ENTRY_W] = {valid_w[k], dirty_w[k], rank_w[k]};
         if (WAY_W'(k) == chosen) begin
            new_tag_row[k*TAG_W +: TAG_W] = req_tag;
            new_state_row[k*ENTRY_W +: ENTRY_W] =
               {1'b1, (hit ? (dirty_w[k] | req_write) : req_write), {WAY_W{1'b0}}};
         end else if (valid_w[k] && (!was_valid || (rank_w[k] < old_rank))
                      && (rank_w[k] != RANK_MAX)) begin
            new_state_row[k*ENTRY_W +: WAY_W] = rank_w[k] + WAY_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/set_assoc_cache_lru_writeback.sv
// Top level of the set-associative, write-back, write-allocate LRU cache controller.
// Depends on salc_pkg, salc_ram, salc_lookup and the assertion macro header.
//
//   Channel | Direction | Handshake           | Payload
//   req     | in        | req_valid/req_stall | req_address, req_is_write
//   rsp     | out       | rsp_valid/rsp_stall | rsp_hit, rsp_writeback, rsp_way, counts
//
// An access first reads the set row from the tag and state RAMs; the row is
// then compared, updated and written back once the output register can take it.
// After reset the state RAM is swept to zero, one set per cycle over all 2**INDEX_BITS
// sets, with req_stall high. A result waits in the output register while the
// next access is taken; a lookup holds its write-back while rsp is stalled and full.
`default_nettype none

module set_assoc_cache_lru_writeback import salc_pkg::*; #(
   parameter int OFFSET_BITS = 5,
   parameter int INDEX_BITS  = 7,
   parameter int WAYS        = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [ADDR_W-1:0]    req_address,
   input  wire logic                 req_is_write,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_hit,
   output logic                      rsp_writeback,
   output logic      [WAY_OUT_W-1:0] rsp_way,
   output salc_count_type            rsp_access_count,
   output salc_count_type            rsp_hit_count,
   output salc_count_type            rsp_miss_count,
   output salc_count_type            rsp_writeback_count
);

   localparam int SETS    = 1 << INDEX_BITS;
   localparam int TAG_W   = ADDR_W - OFFSET_BITS - INDEX_BITS;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ENTRY_W = WAY_W + 2;
   localparam int STATE_ROW_W = WAYS * ENTRY_W;
   localparam int TAG_ROW_W   = WAYS * TAG_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [INDEX_BITS-1:0]  clear_idx_ff, clear_idx_in;
   logic [INDEX_BITS-1:0]  set_ff, set_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic                   write_ff, write_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic                   rsp_writeback_ff, rsp_writeback_in;
   logic [WAY_OUT_W-1:0]   rsp_way_ff, rsp_way_in;
   salc_count_type         access_ff, access_in;
   salc_count_type         hits_ff, hits_in;
   salc_count_type         misses_ff, misses_in;
   salc_count_type         wbacks_ff, wbacks_in;

   logic                   req_xfer;
   logic                   clearing;
   logic                   rsp_load;
   logic [TAG_ROW_W-1:0]   tag_row, new_tag_row;
   logic [STATE_ROW_W-1:0] state_row, new_state_row;
   logic                   st_wr_en;
   logic [INDEX_BITS-1:0]  st_wr_addr;
   logic [STATE_ROW_W-1:0] st_wr_data;
   salc_flags_type         flags;
   logic [WAY_W-1:0]       look_way;
   logic [WAY_W+1:0]       look_way_ext;

   assign clearing  = (state_ff == ST_CLEAR);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   // Finish a lookup once the output register is free or being drained
   assign rsp_load  = (state_ff == ST_LOOK) && (!rsp_valid_ff || !rsp_stall);

   // Tag rows: written only by a finished lookup
   salc_ram #(
      .WIDTH (TAG_ROW_W),
      .DEPTH (SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (rsp_load),
      .wr_addr (set_ff),
      .wr_data (new_tag_row),
      .rd_en   (req_xfer),
      .rd_addr (req_address[OFFSET_BITS +: INDEX_BITS]),
      .rd_data (tag_row)
   );

   // State rows: cleared by the sweep after reset, then updated by lookups
   assign st_wr_en   = clearing || rsp_load;
   assign st_wr_addr = clearing ? clear_idx_ff : set_ff;
   assign st_wr_data = clearing ? '0 : new_state_row;

   salc_ram #(
      .WIDTH (STATE_ROW_W),
      .DEPTH (SETS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (req_xfer),
      .rd_addr (req_address[OFFSET_BITS +: INDEX_BITS]),
      .rd_data (state_row)
   );

   salc_lookup #(
      .WAYS  (WAYS),
      .TAG_W (TAG_W),
      .WAY_W (WAY_W)
   ) u_lookup (
      .tag_row       (tag_row),
      .state_row     (state_row),
      .req_tag       (tag_ff),
      .req_write     (write_ff),
      .flags         (flags),
      .way           (look_way),
      .new_tag_row   (new_tag_row),
      .new_state_row (new_state_row)
   );

   assign look_way_ext = {2'b00, look_way};

   // Sequence: clear sweep, wait for a transfer, look up and write back
   always_comb begin
      state_in     = state_ff;
      clear_idx_in = clear_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_idx_in = clear_idx_ff + INDEX_BITS'(1);
            if (clear_idx_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Capture the request fields on transfer
   assign set_in   = req_xfer ? req_address[OFFSET_BITS +: INDEX_BITS] : set_ff;
   assign tag_in   = req_xfer ? req_address[ADDR_W-1 -: TAG_W] : tag_ff;
   assign write_in = req_xfer ? req_is_write : write_ff;

   // Load the result and advance the counters when a lookup finishes
   assign rsp_valid_in     = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_hit_in       = rsp_load ? flags.hit : rsp_hit_ff;
   assign rsp_writeback_in = rsp_load ? flags.writeback : rsp_writeback_ff;
   assign rsp_way_in       = rsp_load ? look_way_ext[WAY_OUT_W-1:0] : rsp_way_ff;
   assign access_in = rsp_load ? salc_sat_inc(access_ff) : access_ff;
   assign hits_in   = (rsp_load && flags.hit) ? salc_sat_inc(hits_ff) : hits_ff;
   assign misses_in = (rsp_load && !flags.hit) ? salc_sat_inc(misses_ff) : misses_ff;
   assign wbacks_in = (rsp_load && flags.writeback) ? salc_sat_inc(wbacks_ff) : wbacks_ff;

   // Control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         access_ff    <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         wbacks_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         access_ff    <= access_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         wbacks_ff    <= wbacks_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      set_ff           <= set_in;
      tag_ff           <= tag_in;
      write_ff         <= write_in;
      rsp_hit_ff       <= rsp_hit_in;
      rsp_writeback_ff <= rsp_writeback_in;
      rsp_way_ff       <= rsp_way_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_writeback       = rsp_writeback_ff;
   assign rsp_way             = rsp_way_ff;
   assign rsp_access_count    = access_ff;
   assign rsp_hit_count       = hits_ff;
   assign rsp_miss_count      = misses_ff;
   assign rsp_writeback_count = wbacks_ff;

`include "set_assoc_cache_lru_writeback_assert.svh"

   `SALC_ASSERT_IMP(a_clear_blocks_req, clock, reset, state_ff == ST_CLEAR, req_stall, "request taken during clear sweep")
   `SALC_ASSERT_NEXT(a_xfer_starts_lookup, clock, reset, req_xfer, state_ff == ST_LOOK, "transfer did not start a lookup")
   `SALC_ASSERT_NEXT(a_load_shows_result, clock, reset, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE), "finished lookup left no result")
   `SALC_ASSERT_IMP(a_hit_no_writeback, clock, reset, rsp_valid_ff && rsp_hit_ff, !rsp_writeback_ff, "hit reported a writeback")

endmodule

`default_nettype wire
